/* rtl/cmta_pkg.sv */
// Shared types, codes and lookup tables for the color markup converter.
`timescale 1ns / 1ps
package cmta_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Kind of a queued command
  localparam logic [1:0] KIND_BYTE = 2'd0;  // one literal byte
  localparam logic [1:0] KIND_ESC  = 2'd1;  // ESC [ attrs m
  localparam logic [1:0] KIND_MARK = 2'd2;  // end marker, no byte

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_M      = "m";
  localparam logic [7:0] CH_AT     = "@";
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";

  localparam logic [4:0] CHOICE_MAX = 5'd31;

  // Attribute text between '[' and 'm', first char in ch[0]
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] ch;
  } attr_t;

  typedef struct packed {
    logic  hit;
    attr_t attr;
  } look_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       eot;
    attr_t      attr;   // for KIND_BYTE the byte sits in ch[0]
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic attr_t attr1(input logic [7:0] a);
    attr_t r;
    r.len   = 3'd1;
    r.ch    = '0;
    r.ch[0] = a;
    return r;
  endfunction

  function automatic attr_t attr2(input logic [7:0] a, input logic [7:0] b);
    attr_t r;
    r.len   = 3'd2;
    r.ch    = '0;
    r.ch[0] = a;
    r.ch[1] = b;
    return r;
  endfunction

  // Foreground: <weight>;3<color>
  function automatic attr_t fg(input logic [7:0] weight, input logic [7:0] color);
    attr_t r;
    r.len   = 3'd4;
    r.ch[0] = weight;
    r.ch[1] = ";";
    r.ch[2] = "3";
    r.ch[3] = color;
    return r;
  endfunction

  function automatic look_t letter_lookup(input logic [7:0] c);
    look_t r;
    r.hit  = 1'b1;
    r.attr = attr1("0");
    case (c)
      "n": r.attr = attr1("0");
      "d": r.attr = fg("0", "0");
      "b": r.attr = fg("0", "4");
      "g": r.attr = fg("0", "2");
      "c": r.attr = fg("0", "6");
      "r": r.attr = fg("0", "1");
      "m": r.attr = fg("0", "5");
      "y": r.attr = fg("0", "3");
      "w": r.attr = fg("0", "7");
      "D": r.attr = fg("1", "0");
      "B": r.attr = fg("1", "4");
      "G": r.attr = fg("1", "2");
      "C": r.attr = fg("1", "6");
      "R": r.attr = fg("1", "1");
      "M": r.attr = fg("1", "5");
      "Y": r.attr = fg("1", "3");
      "W": r.attr = fg("1", "7");
      "0": r.attr = attr2("4", "0");
      "1": r.attr = attr2("4", "4");
      "2": r.attr = attr2("4", "2");
      "3": r.attr = attr2("4", "6");
      "4": r.attr = attr2("4", "1");
      "5": r.attr = attr2("4", "5");
      "6": r.attr = attr2("4", "3");
      "7": r.attr = attr2("4", "7");
      "l": r.attr = attr1("5");
      "u": r.attr = attr1("4");
      "o": r.attr = attr1("1");
      "e": r.attr = attr1("7");
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Default user colors; an index of 16 or more gives normal
  function automatic attr_t user_lookup(input logic [4:0] k);
    attr_t r;
    case (k)
      5'd1:  r = fg("0", "6");
      5'd2:  r = fg("0", "2");
      5'd3:  r = fg("0", "3");
      5'd4:  r = fg("0", "1");
      5'd5:  r = fg("0", "2");
      5'd6:  r = fg("0", "3");
      5'd7:  r = fg("1", "3");
      5'd8:  r = fg("1", "3");
      5'd9:  r = fg("1", "3");
      5'd10: r = fg("0", "3");
      5'd11: r = fg("0", "6");
      5'd12: r = fg("0", "2");
      5'd13: r = fg("0", "1");
      5'd14: r = fg("0", "6");
      5'd15: r = fg("0", "7");
      default: r = attr1("0");
    endcase
    return r;
  endfunction

  // Random color letter; picks 14 and 15 wrap to the start of the list
  function automatic logic [7:0] rand_letter(input logic [3:0] rp);
    logic [7:0] r;
    case (rp)
      4'd0:  r = "b";
      4'd1:  r = "g";
      4'd2:  r = "c";
      4'd3:  r = "r";
      4'd4:  r = "m";
      4'd5:  r = "y";
      4'd6:  r = "w";
      4'd7:  r = "B";
      4'd8:  r = "G";
      4'd9:  r = "C";
      4'd10: r = "R";
      4'd11: r = "M";
      4'd12: r = "W";
      4'd13: r = "Y";
      4'd14: r = "b";
      4'd15: r = "g";
      default: r = "b";
    endcase
    return r;
  endfunction

endpackage

/* rtl/color_markup_to_ansi.sv */
// Top level of the color markup to ANSI escape converter.
`timescale 1ns / 1ps
// Usage:
//   The input channel takes one text byte per beat with an end-of-text flag
//   and a random pick for "@x". The output channel gives one byte per beat:
//   literal text, or the bytes of an ESC [ attrs m sequence for a color code.
//   last_of_run marks the final output beat caused by one input beat, and
//   text_done the final beat of the whole string. An end-of-text input that
//   yields no byte still gives one beat with byte_valid low.
//   The first output beat of an input passes through the queue, written at
//   the edge that accepts the input beat, and then through the output
//   register. Plain text moves one beat per cycle while the receiver does
//   not stall; a color code leaves one byte at a time, up to seven bytes,
//   from the expander that drains one queue entry one byte at a time. The
//   four-entry queue lets the parser run ahead while an escape is expanding.
//   When the receiver stalls, the output register holds its beat and the
//   queue fills; in_stall rises only once the queue is full.
//   Reset clears parse state, empties the queue and sets color_enable to 1.
//   color_enable sits at APB address 0: 1 renders codes, 0 strips them.
module color_markup_to_ansi #(
  parameter int QUEUE_DEPTH = cmta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  input  logic [3:0]  in_random_pick,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_run,
  output logic        out_text_done,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cmta_pkg::*;

  logic    color_enable_r;
  logic    push, pop;
  entry_t  push_entry, head;
  q_stat_t q_stat;

  // Single register at word 0; bit 2 of the address selects past it
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, color_enable_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_enable_r <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      color_enable_r <= pwdata[0];
    end
  end

  // Parse and classify each beat
  cmta_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .in_random_pick (in_random_pick),
    .color_enable   (color_enable_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  // Decouple parser from expander
  cmta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Expand commands into output bytes
  cmta_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_text_done   (out_text_done)
  );

  // The end of a string always closes the run of its last input beat
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_last_of_run)
    else $error("text_done without last_of_run");

  // A marker beat without a byte only appears at the end of a string
  a_mark_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_text_done && out_byte == 8'd0)
    else $error("empty beat outside end of text");

  // Hold a stalled output beat until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_byte_valid)
      && $stable(out_last_of_run) && $stable(out_text_done))
    else $error("stalled output beat changed");

  // Queue cannot be full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

endmodule

/* rtl/cmta_front.sv */
// Front end: accepts input beats, parses markup and pushes commands.
`timescale 1ns / 1ps
module cmta_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_text,
  input  logic [3:0]       in_random_pick,
  input  logic             color_enable,
  input  cmta_pkg::q_stat_t q_stat,
  output logic             push,
  output cmta_pkg::entry_t push_entry
);
  import cmta_pkg::*;

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_AT     = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  logic [1:0] mode_r, mode_nxt;
  logic [4:0] choice_r, choice_nxt;

  logic       accept;
  logic [1:0] mode;
  logic [7:0] code;
  logic       is_digit;
  logic [3:0] dig;
  logic [8:0] acc;
  logic [4:0] choice_sat;
  look_t      look;
  logic       emit;
  entry_t     ent;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign mode       = (mode_r == MODE_DIGITS || mode_r == MODE_AT) ? mode_r : MODE_TEXT;
  assign code       = (in_byte == CH_X) ? rand_letter(in_random_pick) : in_byte;
  assign look       = letter_lookup(code);
  assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign dig        = 4'(in_byte - CH_ZERO);
  assign acc        = (9'(choice_r) << 3) + (9'(choice_r) << 1) + 9'(dig);
  assign choice_sat = (acc > 9'(CHOICE_MAX)) ? CHOICE_MAX : acc[4:0];

  always_comb begin
    mode_nxt   = mode_r;
    choice_nxt = choice_r;
    emit       = 1'b0;
    ent.kind   = KIND_BYTE;
    ent.eot    = in_end_of_text;
    ent.attr   = attr1(in_byte);
    case (mode)
      MODE_AT: begin
        if (code == CH_LBRACK) begin
          mode_nxt   = MODE_DIGITS;
          choice_nxt = '0;
        end else begin
          mode_nxt = MODE_TEXT;
          if (code == CH_AT) begin
            emit     = 1'b1;
            ent.attr = attr1(CH_AT);
          end else if (color_enable && look.hit) begin
            emit     = 1'b1;
            ent.kind = KIND_ESC;
            ent.attr = look.attr;
          end
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          choice_nxt = choice_sat;
          if (in_end_of_text && color_enable) begin
            emit     = 1'b1;
            ent.kind = KIND_ESC;
            ent.attr = user_lookup(choice_sat);
          end
        end else begin
          mode_nxt = MODE_TEXT;
          if (color_enable) begin
            emit     = 1'b1;
            ent.kind = KIND_ESC;
            ent.attr = user_lookup(choice_r);
          end
        end
      end
      default: begin
        if (in_byte == CH_AT) begin
          if (in_end_of_text) begin
            emit = 1'b1;
          end else begin
            mode_nxt = MODE_AT;
          end
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (in_end_of_text) begin
      mode_nxt   = MODE_TEXT;
      choice_nxt = '0;
    end
    if (!emit) begin
      ent.kind = KIND_MARK;
    end
  end

  assign push       = accept && (emit || in_end_of_text);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_TEXT;
      choice_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      choice_r <= choice_nxt;
    end
  end

endmodule

/* rtl/cmta_queue.sv */
// Command queue between the parser and the byte expander.
`timescale 1ns / 1ps
module cmta_queue #(
  parameter int DEPTH = cmta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmta_pkg::entry_t  push_entry,
  input  logic              pop,
  output cmta_pkg::entry_t  head,
  output cmta_pkg::q_stat_t q_stat
);
  import cmta_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
    end
  end

endmodule

/* rtl/cmta_back.sv */
// Back end: expands queued commands into output beats.
`timescale 1ns / 1ps
module cmta_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cmta_pkg::entry_t  head,
  input  cmta_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_last_of_run,
  output logic              out_text_done
);
  import cmta_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, last_r, done_r;

  logic       advance;
  logic       take;
  logic [2:0] total;
  logic       last;
  logic [1:0] idx;
  logic [7:0] cur_byte;

  assign advance = !valid_r || !out_stall;
  assign take    = advance && !q_stat.empty;
  assign total   = (head.kind == KIND_ESC) ? 3'(head.attr.len + 3'd3) : 3'd1;
  assign last    = (pos_r == 3'(total - 3'd1));
  assign idx     = 2'(pos_r - 3'd2);
  assign pop     = take && last;
  assign pos_nxt = last ? 3'd0 : pos_r + 3'd1;

  always_comb begin
    cur_byte = head.attr.ch[0];
    if (head.kind == KIND_MARK) begin
      cur_byte = '0;
    end else if (head.kind == KIND_ESC) begin
      if (pos_r == 3'd0) begin
        cur_byte = CH_ESC;
      end else if (pos_r == 3'd1) begin
        cur_byte = CH_LBRACK;
      end else if (last) begin
        cur_byte = CH_M;
      end else begin
        cur_byte = head.attr.ch[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r   <= cur_byte;
      bvalid_r <= (head.kind != KIND_MARK);
      last_r   <= last;
      done_r   <= last && head.eot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (advance) begin
        valid_r <= !q_stat.empty;
      end
      if (take) begin
        pos_r <= pos_nxt;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_last_of_run = last_r;
  assign out_text_done   = done_r;

endmodule

/* tb/sv/color_markup_checker.sv */
// Scoreboard for the color markup converter: predicts every output beat and compares.
`timescale 1ns / 1ps
module color_markup_checker #(
  parameter logic [2:0] ENABLE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  input  logic [3:0]  in_random_pick,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic        out_last_of_run,
  input  logic        out_text_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  import cmta_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT     = 2'd0,
    MODE_AFTER_AT = 2'd1,
    MODE_DIGITS   = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       run_end;
    logic       text_end;
  } out_beat_t;

  localparam int RUN_MAX    = 7;
  localparam int PICK_COUNT = 14;

  string       pick_letters = "bgcrmywBGCRMWY";
  out_beat_t   expected_beats[$];
  logic        color_on;
  parse_mode_t mode;
  logic [4:0]  user_idx;
  logic [7:0]  run_bytes[RUN_MAX];
  int          run_len;
  int          fail_count;

  function automatic string code_attrs(input logic [7:0] c, output logic known);
    string s;
    known = 1'b1;
    case (c)
      "n": s = "0";
      "d": s = "0;30";
      "b": s = "0;34";
      "g": s = "0;32";
      "c": s = "0;36";
      "r": s = "0;31";
      "m": s = "0;35";
      "y": s = "0;33";
      "w": s = "0;37";
      "D": s = "1;30";
      "B": s = "1;34";
      "G": s = "1;32";
      "C": s = "1;36";
      "R": s = "1;31";
      "M": s = "1;35";
      "Y": s = "1;33";
      "W": s = "1;37";
      "0": s = "40";
      "1": s = "44";
      "2": s = "42";
      "3": s = "46";
      "4": s = "41";
      "5": s = "45";
      "6": s = "43";
      "7": s = "47";
      "l": s = "5";
      "u": s = "4";
      "o": s = "1";
      "e": s = "7";
      default: begin
        s = "";
        known = 1'b0;
      end
    endcase
    return s;
  endfunction

  // indexes of 16 and up fall back to normal
  function automatic string user_attrs(input logic [4:0] k);
    string s;
    case (k)
      5'd1, 5'd11, 5'd14:       s = "0;36";
      5'd2, 5'd5, 5'd12:        s = "0;32";
      5'd3, 5'd6, 5'd10:        s = "0;33";
      5'd4, 5'd13:              s = "0;31";
      5'd7, 5'd8, 5'd9:         s = "1;33";
      5'd15:                    s = "0;37";
      default:                  s = "0";
    endcase
    return s;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    if (run_len < RUN_MAX) begin
      run_bytes[run_len] = b;
      run_len++;
    end
  endtask

  task automatic add_escape(input string attrs);
    int i;
    add_byte(CH_ESC);
    add_byte(CH_LBRACK);
    for (i = 0; i < attrs.len(); i++)
      add_byte(attrs[i]);
    add_byte(CH_M);
  endtask

  // Advance the parser by one input beat and queue the beats it yields
  task automatic predict_beat(input logic [7:0] c_in, input logic eot, input logic [3:0] pick);
    logic [7:0] c;
    logic       known;
    string      attrs;
    logic [9:0] acc;
    int         k;
    out_beat_t  beat;
    c = c_in;
    run_len = 0;
    case (mode)
      MODE_AFTER_AT: begin
        if (c == CH_X)
          c = pick_letters[pick >= PICK_COUNT ? pick - PICK_COUNT : pick];
        if (c == CH_LBRACK) begin
          mode = MODE_DIGITS;
          user_idx = '0;
        end else begin
          mode = MODE_TEXT;
          if (c == CH_AT) begin
            add_byte(CH_AT);
          end else if (color_on) begin
            attrs = code_attrs(c, known);
            if (known)
              add_escape(attrs);
          end
        end
      end
      MODE_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          acc = 10'(user_idx * 10 + (c - CH_ZERO));
          user_idx = (acc > CHOICE_MAX) ? CHOICE_MAX : acc[4:0];
          if (eot && color_on)
            add_escape(user_attrs(user_idx));
        end else begin
          if (color_on)
            add_escape(user_attrs(user_idx));
          mode = MODE_TEXT;
        end
      end
      default: begin
        if (c == CH_AT) begin
          if (eot)
            add_byte(CH_AT);
          else
            mode = MODE_AFTER_AT;
        end else begin
          add_byte(c);
        end
      end
    endcase
    if (eot) begin
      mode = MODE_TEXT;
      user_idx = '0;
    end
    if (run_len == 0) begin
      if (eot) begin
        beat = '{data: 8'h00, has_byte: 1'b0, run_end: 1'b1, text_end: 1'b1};
        expected_beats = {expected_beats, beat};
      end
    end else begin
      for (k = 0; k < run_len; k++) begin
        beat = '{data: run_bytes[k], has_byte: 1'b1,
                 run_end: k == run_len - 1,
                 text_end: (k == run_len - 1) && eot};
        expected_beats = {expected_beats, beat};
      end
    end
  endtask

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_n) begin
      color_on = 1'b1;
      mode = MODE_TEXT;
      user_idx = '0;
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR)
        color_on = pwdata[0];
      if (out_valid && !out_stall) begin
        got = {out_byte, out_byte_valid, out_last_of_run, out_text_done};
        if (expected_beats.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output beat: byte %h valid %b last %b done %b",
                   $time, got.data, got.has_byte, got.run_end, got.text_end);
        end else begin
          want = expected_beats.pop_front();
          if (got != want) begin
            fail_count++;
            $display({"%0t: expected byte %h valid %b last %b done %b,",
                      " got byte %h valid %b last %b done %b"},
                     $time, want.data, want.has_byte, want.run_end, want.text_end,
                     got.data, got.has_byte, got.run_end, got.text_end);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_beat(in_byte, in_end_of_text, in_random_pick);
    end
    mismatches  <= fail_count;
    outstanding <= expected_beats.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the color markup converter testbench: stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module testbench;
  import cmta_pkg::*;

  localparam logic [2:0] ENABLE_ADDR = 3'd0;   // color_enable register
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE_CYCLES = 8;    // margin past the last output beat

  typedef enum logic [1:0] {
    STALL_NONE   = 2'd0,
    STALL_LIGHT  = 2'd1,
    STALL_HEAVY  = 2'd2,
    STALL_PERIOD = 2'd3
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h20;
  logic        in_end_of_text = 1'b0;
  logic [3:0]  in_random_pick = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_of_run;
  logic        out_text_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int           mismatches;
  int           outstanding;
  int           cycle_count = 0;
  int           burst_left = 0;
  stall_style_t stall_style = STALL_NONE;
  int           stall_span = 0;
  logic [7:0]   token_q[$];
  string        code_letters = "ndbgcrmywDBGCRMYW01234567luoe";

  color_markup_to_ansi dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .in_random_pick (in_random_pick),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_of_run(out_last_of_run),
    .out_text_done  (out_text_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  color_markup_checker #(.ENABLE_ADDR(ENABLE_ADDR)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .in_random_pick (in_random_pick),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_of_run(out_last_of_run),
    .out_text_done  (out_text_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver stall: switch between randomly chosen styles so that
  // stalls land on every stage of an escape expansion, with quiet stretches too.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_span  <= $urandom_range(20, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 1) == 0);
      default:      out_stall <= (cycle_count % 8 >= 5);
    endcase
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted. The sender runs in bursts;
  // a burst ends with an idle gap, unless the gap comes out as zero, in
  // which case valid stays high so it is never dropped and raised in one step.
  task automatic send_beat(input logic [7:0] b, input logic eot, input logic [3:0] pick);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    in_random_pick <= pick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Append one byte to the pending token.
  task automatic add_token(input logic [7:0] b);
    token_q = {token_q, b};
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      add_token(s[i]);
  endtask

  // Send the queued token; end_of_text rides on its final byte if asked.
  task automatic send_token(input logic eot_last, input logic [3:0] pick);
    int i;
    for (i = 0; i < token_q.size(); i++)
      send_beat(token_q[i], eot_last && (i == token_q.size() - 1), pick);
    token_q.delete();
  endtask

  // Drop valid, wait for every predicted beat, then let the pipeline drain
  // beats that produced nothing before the configuration changes.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_enable(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_text();
    // byte extremes, end on a plain byte
    add_token(8'hFF);
    add_token(8'h01);
    send_token(1'b1, 4'd0);
    push_text("@@");
    send_token(1'b0, 4'd3);
    // random pick past the list wraps to its start
    push_text("@x");
    send_token(1'b0, 4'd15);
    push_text("@x");
    send_token(1'b0, 4'd13);
    // unknown code is dropped
    push_text("@!");
    send_token(1'b0, 4'd5);
    push_text("@[12z");
    send_token(1'b0, 4'd8);
    // a sign ends the digits; no digits means user color zero
    push_text("@[-");
    send_token(1'b0, 4'd1);
    // saturating index at end of text gives normal
    push_text("@[999");
    send_token(1'b1, 4'd14);
    // bracket at end of text yields only the end marker
    push_text("@[");
    send_token(1'b1, 4'd2);
    // trailing at sign is kept
    push_text("@");
    send_token(1'b1, 4'd7);
  endtask

  // Mostly well-formed color codes with random content, plus plain text and noise.
  task automatic random_text(input int count);
    int         sent;
    int         kind;
    int         ndig;
    int         i;
    logic       eot;
    logic [7:0] b;
    logic [3:0] pick;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      pick = 4'($urandom_range(0, 15));
      eot  = ($urandom_range(0, 7) == 0);
      if (kind < 30) begin
        b = 8'($urandom_range(1, 255));
        if (b == CH_AT)
          b = "a";
        add_token(b);
      end else if (kind < 55) begin
        add_token(CH_AT);
        add_token(code_letters[$urandom_range(0, code_letters.len() - 1)]);
      end else if (kind < 65) begin
        push_text("@x");
      end else if (kind < 70) begin
        push_text("@@");
      end else if (kind < 85) begin
        push_text("@[");
        ndig = $urandom_range(0, 3);
        for (i = 0; i < ndig; i++)
          add_token(8'(CH_ZERO + $urandom_range(0, 9)));
        // either stop on the last digit with end of text, or add a terminator
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 3))
            0: b = " ";
            1: b = "-";
            2: b = "+";
            default: begin
              b = 8'($urandom_range(1, 255));
              if (b >= CH_ZERO && b <= CH_NINE)
                b = "z";
            end
          endcase
          add_token(b);
        end else begin
          eot = 1'b1;
        end
      end else if (kind < 90) begin
        add_token(CH_AT);
        eot = 1'b1;
      end else begin
        add_token(8'($urandom_range(1, 255)));
      end
      sent += token_q.size();
      send_token(eot, pick);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_enable(1'b1);
    directed_text();
    settle();

    // alternate stripping and rendering across the random phases
    write_enable(1'b0);
    random_text(25);
    settle();
    write_enable(1'b1);
    random_text(26);
    settle();
    write_enable(1'b0);
    random_text(25);
    settle();
    write_enable(1'b1);
    random_text(26);
    settle();

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
